// ===== src/fdsu_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsu_pkg: shared definitions for the Forth data stack unit
// Word codes, status and print codes, sequencer states, the request and
// response bundles of the multiply/divide unit, and small helper functions.
// ----------------------------------------------------------------------------
package fdsu_pkg;

    localparam int WORD_W              = 32;
    localparam int OP_W                = 5;
    localparam int STATUS_W            = 3;
    localparam int KIND_W              = 2;
    localparam int DEPTH_W             = 7;
    localparam int DEFAULT_STACK_DEPTH = 64;

    // Word codes.
    localparam logic [OP_W-1:0] OP_PUSH = 5'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 5'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 5'd4;
    localparam logic [OP_W-1:0] OP_EMIT = 5'd5;
    localparam logic [OP_W-1:0] OP_CR   = 5'd6;
    localparam logic [OP_W-1:0] OP_DOT  = 5'd7;
    localparam logic [OP_W-1:0] OP_DUP  = 5'd8;
    localparam logic [OP_W-1:0] OP_DROP = 5'd9;
    localparam logic [OP_W-1:0] OP_SWAP = 5'd10;
    localparam logic [OP_W-1:0] OP_OVER = 5'd11;
    localparam logic [OP_W-1:0] OP_ROT  = 5'd12;
    localparam logic [OP_W-1:0] OP_EQ   = 5'd13;
    localparam logic [OP_W-1:0] OP_LT   = 5'd14;
    localparam logic [OP_W-1:0] OP_GT   = 5'd15;
    localparam logic [OP_W-1:0] OP_AND  = 5'd16;
    localparam logic [OP_W-1:0] OP_OR   = 5'd17;
    localparam logic [OP_W-1:0] OP_NOT  = 5'd18;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDER = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OVER  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZ  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FLAG  = 3'd4;

    // Print kinds.
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd3;

    localparam logic [WORD_W-1:0] TRUE_FLAG = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_READ_C,
        ST_EXEC,
        ST_MULDIV,
        ST_WRITE,
        ST_RESP
    } fdsu_state_t;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [WORD_W-1:0] opa;    // multiplicand or dividend
        logic [WORD_W-1:0] opb;    // multiplier or divisor
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } md_rsp_t;

    // Number of stack entries a word needs before it can run.
    function automatic logic [1:0] need_count(input logic [OP_W-1:0] op);
        logic [1:0] n;
        unique case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_OVER,
            OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR:      n = 2'd2;
            OP_EMIT, OP_DOT, OP_DUP, OP_DROP, OP_NOT: n = 2'd1;
            OP_ROT:                                    n = 2'd3;
            default:                                   n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_flag(input logic [WORD_W-1:0] v);
        return (v == '0) || (v == TRUE_FLAG);
    endfunction

endpackage

// ===== src/fdsu_muldiv.sv =====
// ----------------------------------------------------------------------------
// fdsu_muldiv: iterative multiply/divide unit
// Shift-add multiply (low word of the product) and restoring signed divide
// truncating toward zero, one bit per cycle through one shared adder.
// ----------------------------------------------------------------------------
module fdsu_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  fdsu_pkg::md_req_t req,
    output fdsu_pkg::md_rsp_t rsp
);
    import fdsu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam int ADD_W = WORD_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              is_div_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] shx_reg;
    logic [WORD_W-1:0] shy_reg;

    logic [ADD_W-1:0]  shifted_rem;
    logic [ADD_W-1:0]  add_x;
    logic [ADD_W-1:0]  add_y;
    logic              add_cin;
    logic [ADD_W-1:0]  add_sum;
    logic              sub_neg;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] quotient;

    // The one adder: accumulate for multiply, trial subtract for divide.
    always_comb begin
        shifted_rem = {1'b0, acc_reg, shx_reg[WORD_W-1]};
        if (is_div_reg) begin
            add_x   = shifted_rem;
            add_y   = ~{2'b00, shy_reg};
            add_cin = 1'b1;
        end else begin
            add_x   = {2'b00, acc_reg};
            add_y   = {2'b00, shx_reg};
            add_cin = 1'b0;
        end
        add_sum = add_x + add_y + ADD_W'(add_cin);
        sub_neg = add_sum[ADD_W-1];
    end

    assign mag_a    = req.opa[WORD_W-1] ? (~req.opa + WORD_W'(1)) : req.opa;
    assign mag_b    = req.opb[WORD_W-1] ? (~req.opb + WORD_W'(1)) : req.opb;
    assign quotient = neg_reg ? (~shx_reg + WORD_W'(1)) : shx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            is_div_reg <= req.is_div;
            acc_reg    <= '0;
            if (req.is_div) begin
                shx_reg <= mag_a;
                shy_reg <= mag_b;
                neg_reg <= req.opa[WORD_W-1] ^ req.opb[WORD_W-1];
            end else begin
                shx_reg <= req.opa;
                shy_reg <= req.opb;
                neg_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            if (is_div_reg) begin
                acc_reg <= sub_neg ? shifted_rem[WORD_W-1:0] : add_sum[WORD_W-1:0];
                shx_reg <= {shx_reg[WORD_W-2:0], ~sub_neg};
            end else begin
                if (shy_reg[0]) begin
                    acc_reg <= add_sum[WORD_W-1:0];
                end
                shx_reg <= {shx_reg[WORD_W-2:0], 1'b0};
                shy_reg <= {1'b0, shy_reg[WORD_W-1:1]};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = is_div_reg ? quotient : acc_reg;

endmodule

// ===== src/fdsu_stack_mem.sv =====
// ----------------------------------------------------------------------------
// fdsu_stack_mem: data stack storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdsu_stack_mem #(
    parameter int DEPTH  = fdsu_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [fdsu_pkg::WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [fdsu_pkg::WORD_W-1:0] rd_data
);
    import fdsu_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/forth_data_stack_unit.sv =====
// ----------------------------------------------------------------------------
// forth_data_stack_unit: Forth word executor on a bounded data stack
// Runs one Forth word per input beat and returns one result beat with the
// status, anything printed, the new top of stack and the new depth.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                         Direction
//   -------  --------------------------------------------  ---------
//   s_       s_valid/s_ready, s_operation, s_literal       input
//   m_       m_valid/m_ready, m_status, m_print_kind,      output
//            m_print_value, m_top_value, m_depth
//
// A beat runs through the sequencer states in order: read the second and
// third entries (skipped for words without operands: push, cr and unassigned
// codes), execute, iterate for multiply and divide, write and respond. The
// next beat can be accepted only once the word has responded. The stack
// memory has a single read port, so the second and third entries are fetched
// one per cycle, and swap and rotate write their entries one per cycle.
// Multiply and divide go through a shared bit-serial unit. The result beat
// appears in the output register in the cycle after the last step of its word.
// Reset clears the entry count, the sequencer and the output valid; stack
// contents are not cleared since only entries below the count are ever used.
// A stalled result holds in the output register. The next word is accepted
// and run meanwhile, but it waits in its last step until the register is
// taken, and no further beat is accepted until then.
// ----------------------------------------------------------------------------
module forth_data_stack_unit #(
    parameter int STACK_DEPTH = fdsu_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fdsu_pkg::OP_W-1:0]            s_operation,
    input  logic signed [fdsu_pkg::WORD_W-1:0]   s_literal,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fdsu_pkg::STATUS_W-1:0]        m_status,
    output logic [fdsu_pkg::KIND_W-1:0]          m_print_kind,
    output logic signed [fdsu_pkg::WORD_W-1:0]   m_print_value,
    output logic signed [fdsu_pkg::WORD_W-1:0]   m_top_value,
    output logic [fdsu_pkg::DEPTH_W-1:0]         m_depth
);
    import fdsu_pkg::*;

    // The count has to hold the full depth; addresses only reach depth - 1.
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    fdsu_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg;
    logic [WORD_W-1:0]   top_reg;
    logic [OP_W-1:0]     op_reg;
    logic [WORD_W-1:0]   lit_reg;
    logic [WORD_W-1:0]   a_reg;     // top of stack at acceptance
    logic [WORD_W-1:0]   b_reg;     // entry below the top
    logic [WORD_W-1:0]   c_reg;     // entry below b
    logic [WORD_W-1:0]   res_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [1:0]          wr_num_reg;
    logic [1:0]          wr_idx_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [WORD_W-1:0]   out_pval_reg;
    logic [WORD_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;

    // Stack memory port signals.
    logic                mem_we;
    logic [CNT_W-1:0]    wr_addr_full;
    logic [WORD_W-1:0]   wr_data;
    logic [CNT_W-1:0]    rd_addr_full;
    logic [WORD_W-1:0]   rd_data;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic [CNT_W-1:0]    n_m1;
    logic [CNT_W-1:0]    n_m2;
    logic [CNT_W-1:0]    n_m3;
    logic [CNT_W-1:0]    n_p1;

    // Execute-stage decisions.
    logic                underflow;
    logic                full;
    logic [STATUS_W-1:0] exec_status;
    logic [WORD_W-1:0]   alu_res;
    logic [1:0]          exec_wr_num;
    logic                exec_md;
    logic                write_last;

    // Values committed when the result beat is formed.
    logic [CNT_W-1:0]    new_count;
    logic [WORD_W-1:0]   new_top;
    logic [KIND_W-1:0]   new_kind;
    logic [WORD_W-1:0]   new_pval;
    logic                out_free;
    logic                commit;

    assign n_m1 = count_reg - CNT_W'(1);
    assign n_m2 = count_reg - CNT_W'(2);
    assign n_m3 = count_reg - CNT_W'(3);
    assign n_p1 = count_reg + CNT_W'(1);

    // The output register can take a new beat when it is empty or being read.
    assign out_free = !out_valid_reg || m_ready;

    fdsu_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr_full[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    fdsu_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    // Status, ALU result and write count, evaluated in the execute cycle.
    // Underflow is checked first, then the word's own failure conditions.
    always_comb begin
        underflow = count_reg < CNT_W'(need_count(op_reg));
        full      = count_reg == CNT_W'(STACK_DEPTH);

        if (underflow) begin
            exec_status = STAT_UNDER;
        end else if (full && (op_reg == OP_PUSH || op_reg == OP_DUP || op_reg == OP_OVER)) begin
            exec_status = STAT_OVER;
        end else if (op_reg == OP_DIV && a_reg == '0) begin
            exec_status = STAT_DIVZ;
        end else if (op_reg == OP_AND && (!is_flag(a_reg) || !is_flag(b_reg))) begin
            exec_status = STAT_FLAG;
        end else if (op_reg == OP_NOT && !is_flag(a_reg)) begin
            exec_status = STAT_FLAG;
        end else begin
            exec_status = STAT_OK;
        end

        unique case (op_reg)
            OP_ADD:  alu_res = b_reg + a_reg;
            OP_SUB:  alu_res = b_reg - a_reg;
            OP_EQ:   alu_res = (b_reg == a_reg) ? TRUE_FLAG : '0;
            OP_LT:   alu_res = ($signed(b_reg) < $signed(a_reg)) ? TRUE_FLAG : '0;
            OP_GT:   alu_res = ($signed(a_reg) < $signed(b_reg)) ? TRUE_FLAG : '0;
            OP_AND:  alu_res = (a_reg == TRUE_FLAG && b_reg == TRUE_FLAG) ? TRUE_FLAG : '0;
            OP_OR:   alu_res = (a_reg == TRUE_FLAG || b_reg == TRUE_FLAG) ? TRUE_FLAG : '0;
            OP_NOT:  alu_res = (a_reg == TRUE_FLAG) ? '0 : TRUE_FLAG;
            default: alu_res = '0;
        endcase

        if (exec_status != STAT_OK) begin
            exec_wr_num = 2'd0;
        end else begin
            unique case (op_reg)
                OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DUP, OP_OVER,
                OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR, OP_NOT: exec_wr_num = 2'd1;
                OP_SWAP:                                      exec_wr_num = 2'd2;
                OP_ROT:                                       exec_wr_num = 2'd3;
                default:                                      exec_wr_num = 2'd0;
            endcase
        end

        exec_md = (exec_status == STAT_OK) && (op_reg == OP_MUL || op_reg == OP_DIV);
    end

    // Address and data of the current write slot.
    always_comb begin
        unique case (op_reg)
            OP_PUSH: begin
                wr_addr_full = count_reg;
                wr_data      = lit_reg;
            end
            OP_DUP: begin
                wr_addr_full = count_reg;
                wr_data      = a_reg;
            end
            OP_OVER: begin
                wr_addr_full = count_reg;
                wr_data      = b_reg;
            end
            OP_NOT: begin
                wr_addr_full = n_m1;
                wr_data      = res_reg;
            end
            OP_SWAP: begin
                if (wr_idx_reg == 2'd0) begin
                    wr_addr_full = n_m1;
                    wr_data      = b_reg;
                end else begin
                    wr_addr_full = n_m2;
                    wr_data      = a_reg;
                end
            end
            OP_ROT: begin
                if (wr_idx_reg == 2'd0) begin
                    wr_addr_full = n_m3;
                    wr_data      = b_reg;
                end else if (wr_idx_reg == 2'd1) begin
                    wr_addr_full = n_m2;
                    wr_data      = a_reg;
                end else begin
                    wr_addr_full = n_m1;
                    wr_data      = c_reg;
                end
            end
            default: begin
                // Two-operand words replace the second entry with the result.
                wr_addr_full = n_m2;
                wr_data      = res_reg;
            end
        endcase
    end

    assign write_last = (wr_num_reg == 2'd0) || (wr_idx_reg == wr_num_reg - 2'd1);

    // New count, top and print fields from the registered word outcome.
    always_comb begin
        new_count = count_reg;
        new_top   = a_reg;
        new_kind  = KIND_NONE;
        new_pval  = '0;
        if (status_reg == STAT_OK) begin
            unique case (op_reg)
                OP_PUSH: begin
                    new_count = n_p1;
                    new_top   = lit_reg;
                end
                OP_DUP: begin
                    new_count = n_p1;
                end
                OP_OVER: begin
                    new_count = n_p1;
                    new_top   = b_reg;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR: begin
                    new_count = n_m1;
                    new_top   = res_reg;
                end
                OP_NOT: begin
                    new_top = res_reg;
                end
                OP_EMIT: begin
                    new_count = n_m1;
                    new_top   = b_reg;
                    new_kind  = KIND_CHAR;
                    new_pval  = {{(WORD_W-8){1'b0}}, a_reg[7:0]};
                end
                OP_DOT: begin
                    new_count = n_m1;
                    new_top   = b_reg;
                    new_kind  = KIND_NUMBER;
                    new_pval  = a_reg;
                end
                OP_DROP: begin
                    new_count = n_m1;
                    new_top   = b_reg;
                end
                OP_CR: begin
                    new_kind = KIND_NEWLINE;
                end
                OP_SWAP: begin
                    new_top = b_reg;
                end
                OP_ROT: begin
                    new_top = c_reg;
                end
                default: begin
                    // Unknown codes do nothing and report success.
                    new_count = count_reg;
                end
            endcase
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (need_count(s_operation) == 2'd0) ? ST_EXEC : ST_READ_B;
                end
            end
            ST_READ_B: state_next = ST_READ_C;
            ST_READ_C: state_next = ST_EXEC;
            ST_EXEC:   state_next = exec_md ? ST_MULDIV : ST_WRITE;
            ST_MULDIV: begin
                if (md_rsp.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (write_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // The word finishes once the output register can take its beat.
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready       = state_reg == ST_IDLE;
        mem_we        = (state_reg == ST_WRITE) && (wr_num_reg != 2'd0);
        commit        = (state_reg == ST_RESP) && out_free;
        rd_addr_full  = (state_reg == ST_READ_B) ? n_m2 : n_m3;
        md_req.start  = (state_reg == ST_EXEC) && exec_md;
        md_req.is_div = op_reg == OP_DIV;
        md_req.opa    = b_reg;
        md_req.opb    = a_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg     <= new_count;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            lit_reg <= s_literal;
            a_reg   <= top_reg;
        end
        if (state_reg == ST_READ_C) begin
            b_reg <= rd_data;
        end
        if (state_reg == ST_EXEC) begin
            c_reg      <= rd_data;
            res_reg    <= alu_res;
            status_reg <= exec_status;
            wr_num_reg <= exec_wr_num;
            wr_idx_reg <= 2'd0;
        end
        if (state_reg == ST_MULDIV && md_rsp.done) begin
            res_reg <= md_rsp.result;
        end
        if (mem_we) begin
            wr_idx_reg <= wr_idx_reg + 2'd1;
        end
        if (commit) begin
            top_reg        <= new_top;
            out_status_reg <= status_reg;
            out_kind_reg   <= new_kind;
            out_pval_reg   <= new_pval;
            out_top_reg    <= (new_count == '0) ? '0 : new_top;
            out_depth_reg  <= DEPTH_W'(new_count);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_print_kind  = out_kind_reg;
    assign m_print_value = out_pval_reg;
    assign m_top_value   = out_top_reg;
    assign m_depth       = out_depth_reg;

endmodule

// ===== src/fdsu_checker.sv =====
// ----------------------------------------------------------------------------
// fdsu_checker: port-level checks for the Forth data stack unit
// Watches the handshake and the result fields on the top-level ports.
// ----------------------------------------------------------------------------
module fdsu_checker #(
    parameter int STACK_DEPTH = fdsu_pkg::DEFAULT_STACK_DEPTH
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [fdsu_pkg::STATUS_W-1:0]        m_status,
    input logic [fdsu_pkg::KIND_W-1:0]          m_print_kind,
    input logic signed [fdsu_pkg::WORD_W-1:0]   m_print_value,
    input logic signed [fdsu_pkg::WORD_W-1:0]   m_top_value,
    input logic [fdsu_pkg::DEPTH_W-1:0]         m_depth
);
    import fdsu_pkg::*;

    // Every word runs through further sequencer states, so ready drops right after an input beat.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A failed word prints nothing.
    a_fail_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_print_kind == KIND_NONE && m_print_value == '0))
        else $error("failed word reported a print");

    // Emit prints a byte, and the depth never passes the stack size.
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_print_kind != KIND_CHAR || m_print_value[WORD_W-1:8] == '0)
                     && m_depth <= STACK_DEPTH))
        else $error("result field out of range");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_top_value) && $stable(m_depth)
                                   && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

bind forth_data_stack_unit fdsu_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_fdsu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_print_kind  (m_print_kind),
    .m_print_value (m_print_value),
    .m_top_value   (m_top_value),
    .m_depth       (m_depth)
);
